// File: sv/mwtg_pkg.sv
// Shared constants for the multiwave tone generator: register indexes, wave codes and scalars.
package mwtg_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BEAT_STEP   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WAVE_SELECT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_VOLUME      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RISE_HOLD   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_FALL_REST   = 3'd6;

  localparam logic [2:0] WAVE_SINE     = 3'd0;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
  localparam logic [2:0] WAVE_SQUARE   = 3'd2;
  localparam logic [2:0] WAVE_SAWTOOTH = 3'd3;
  localparam logic [2:0] WAVE_BINAURAL = 3'd4;

  localparam logic [7:0] VOLUME_RESET = 8'd128;

  localparam logic signed [15:0] FULL_AMP = 16'sd32767;

  localparam logic [16:0] ENV_FULL = 17'h10000;

  // Reciprocal of 255 scaled by 2^31, rounded up.
  localparam logic [23:0] RECIP_255    = 24'd8421505;
  localparam int          RECIP_SHIFT  = 31;
  localparam logic [23:0] DIVISOR_255  = 24'd255;

  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

endpackage

// File: sv/multiwave_tone_generator_unit.sv
// Tone generator top level: phase accumulators, sine table, envelope divider and scaling sequencer.
//
//   channel   signals                          payload          direction
//   request   req_valid / req_stall            elapsed_ms       in
//   sample    sample_valid / sample_stall      audio_sample     out
//   config    cfg_write_en / cfg_index         cfg_data         in
//
// A beat runs both 32-step restoring divisions when the envelope is on (time modulo the cycle
// length, then segment progress), only the first in a flat or silent segment, neither without
// the envelope and no table or scaling steps with audio off; binaural adds S_RAW3 for its second table read.
// Reset is synchronous and returns the config registers, the state, sample_valid and both phases to reset values.
// A new request is taken only while the sequencer is idle; a finished sample waits in the
// output register, and the sequencer holds in its last step while that register is full and stalled.
module multiwave_tone_generator_unit #(
  parameter int SINE_TABLE_ENTRIES = 1024,
  parameter int PHASE_BITS         = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [31:0]                         elapsed_ms,
  output logic                                sample_valid,
  input  logic                                sample_stall,
  output logic signed [15:0]                  audio_sample,
  input  logic                                cfg_write_en,
  input  logic [mwtg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mwtg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDX_W   = $clog2(SINE_TABLE_ENTRIES);
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RAW0 = 4'd1;
  localparam logic [3:0] S_RAW1 = 4'd2;
  localparam logic [3:0] S_RAW2 = 4'd3;
  localparam logic [3:0] S_RAW3 = 4'd4;
  localparam logic [3:0] S_ENV0 = 4'd5;
  localparam logic [3:0] S_DIVM = 4'd6;
  localparam logic [3:0] S_SEG  = 4'd7;
  localparam logic [3:0] S_DIVE = 4'd8;
  localparam logic [3:0] S_SC0  = 4'd9;
  localparam logic [3:0] S_SC1  = 4'd10;
  localparam logic [3:0] S_SC2  = 4'd11;
  localparam logic [3:0] S_SC3  = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  // Sine table, worked out at elaboration with a Q2.30 series per entry.
  logic signed [15:0] sine_rom [SINE_TABLE_ENTRIES];

  for (genvar k = 0; k < SINE_TABLE_ENTRIES; k++) begin : g_rom
    localparam longint R4   = 4 * k;
    localparam longint QUAD = R4 / SINE_TABLE_ENTRIES;
    localparam longint REMK = R4 % SINE_TABLE_ENTRIES;
    localparam longint XA   = (mwtg_pkg::HALF_PI_Q30 * REMK) / SINE_TABLE_ENTRIES;
    localparam bit     ODD  = (QUAD % 2) == 0;
    localparam longint X2   = (XA * XA) >>> 30;
    localparam longint D1   = ODD ? 6 : 2;
    localparam longint D2   = ODD ? 20 : 12;
    localparam longint D3   = ODD ? 42 : 30;
    localparam longint D4   = ODD ? 72 : 56;
    localparam longint D5   = ODD ? 110 : 90;
    localparam longint D6   = ODD ? 156 : 132;
    localparam longint D7   = ODD ? 210 : 182;
    localparam longint T0   = ODD ? XA : mwtg_pkg::ONE_Q30;
    localparam longint T1   = ((T0 * X2) >>> 30) / D1;
    localparam longint T2   = ((T1 * X2) >>> 30) / D2;
    localparam longint T3   = ((T2 * X2) >>> 30) / D3;
    localparam longint T4   = ((T3 * X2) >>> 30) / D4;
    localparam longint T5   = ((T4 * X2) >>> 30) / D5;
    localparam longint T6   = ((T5 * X2) >>> 30) / D6;
    localparam longint T7   = ((T6 * X2) >>> 30) / D7;
    localparam longint SUM  = T0 - T1 + T2 - T3 + T4 - T5 + T6 - T7;
    localparam longint SCL  = (SUM < 0) ? 64'sd0 :
                              ((SUM > mwtg_pkg::ONE_Q30) ? mwtg_pkg::ONE_Q30 : SUM);
    localparam longint MAG  = (SCL * 32767) >>> 30;
    localparam longint VAL  = (QUAD >= 2) ? -MAG : MAG;
    assign sine_rom[k] = 16'(VAL);
  end

  // Configuration registers.
  logic [PHASE_BITS-1:0] phase_step;
  logic [PHASE_BITS-1:0] beat_step;
  logic [2:0]            wave_select;
  logic [7:0]            volume_level;
  logic [1:0]            enable_bits;
  logic [31:0]           rise_hold_ms;
  logic [31:0]           fall_rest_ms;

  // Sequencer and datapath registers.
  logic [3:0]              state;
  logic [PHASE_BITS-1:0]   main_phase;
  logic [PHASE_BITS-1:0]   beat_phase;
  logic [31:0]             elapsed;
  logic signed [15:0]      raw;
  logic signed [15:0]      sine_first;
  logic signed [15:0]      rom_q;
  logic [PROD_W-1:0]       prod;
  logic [31:0]             dq;
  logic [17:0]             rem;
  logic [17:0]             divisor;
  logic [4:0]              cnt;
  logic [16:0]             env;
  logic [22:0]             tsc;
  logic signed [15:0]      result;

  // Combinational signals.
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [31:0]        p32;
  logic [32:0]        vmag;
  logic               vneg;
  logic [IDX_W-1:0]   rom_idx;
  logic [18:0]        rem_sh;
  logic               div_ge;
  logic [17:0]        rem_new;
  logic [31:0]        dq_new;
  logic [17:0]        c0;
  logic [17:0]        c01;
  logic [17:0]        c012;
  logic [17:0]        total;
  logic [17:0]        fall_left;
  logic [15:0]        raw_abs;
  logic [15:0]        q0;
  logic [23:0]        q0_x255;
  logic [23:0]        rr;
  logic [15:0]        q_fix;
  logic [16:0]        bin_sum;
  logic [16:0]        bin_half;
  logic               out_free;
  logic               accept;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !sample_valid || !sample_stall;

  assign p32 = 32'(main_phase) << (32 - PHASE_BITS);

  always_comb begin
    vmag = '0;
    vneg = 1'b0;
    if (wave_select == mwtg_pkg::WAVE_SAWTOOTH) begin
      if (p32[31]) begin
        vmag = (33'(p32) - 33'h0_8000_0000) << 1;
      end else begin
        vmag = (33'h0_8000_0000 - 33'(p32)) << 1;
        vneg = 1'b1;
      end
    end else begin
      unique case (p32[31:30])
        2'b00: vmag = {1'b0, p32[29:0], 2'b00};
        2'b01: vmag = (33'h0_8000_0000 - 33'(p32)) << 2;
        2'b10: begin
          vmag = (33'(p32) - 33'h0_8000_0000) << 2;
          vneg = 1'b1;
        end
        default: begin
          vmag = (33'h1_0000_0000 - 33'(p32)) << 2;
          vneg = 1'b1;
        end
      endcase
    end
  end

  assign raw_abs = raw[15] ? 16'(-raw) : 16'(raw);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_RAW0, S_RAW1: begin
        if (wave_select == mwtg_pkg::WAVE_TRIANGLE || wave_select == mwtg_pkg::WAVE_SAWTOOTH) begin
          mul_a = vmag;
          mul_b = MUL_B_W'(mwtg_pkg::FULL_AMP);
        end else if (state == S_RAW1 && wave_select == mwtg_pkg::WAVE_BINAURAL) begin
          mul_a = MUL_A_W'(beat_phase);
          mul_b = MUL_B_W'(SINE_TABLE_ENTRIES);
        end else begin
          mul_a = MUL_A_W'(main_phase);
          mul_b = MUL_B_W'(SINE_TABLE_ENTRIES);
        end
      end
      S_SC0: begin
        mul_a = MUL_A_W'(raw_abs);
        mul_b = MUL_B_W'(volume_level);
      end
      S_SC1: begin
        mul_a = MUL_A_W'(prod[22:0]);
        mul_b = MUL_B_W'(env);
      end
      S_SC2: begin
        mul_a = MUL_A_W'(prod[38:16]);
        mul_b = mwtg_pkg::RECIP_255;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rom_idx = prod[PHASE_BITS +: IDX_W];

  // One restoring division step.
  assign rem_sh  = {rem, dq[31]};
  assign div_ge  = rem_sh >= {1'b0, divisor};
  assign rem_new = div_ge ? 18'(rem_sh - {1'b0, divisor}) : 18'(rem_sh);
  assign dq_new  = {dq[30:0], div_ge};

  assign c0        = {2'b00, rise_hold_ms[15:0]};
  assign c01       = c0 + {2'b00, rise_hold_ms[31:16]};
  assign c012      = c01 + {2'b00, fall_rest_ms[15:0]};
  assign total     = c012 + {2'b00, fall_rest_ms[31:16]};
  assign fall_left = c012 - rem;

  assign q0      = prod[mwtg_pkg::RECIP_SHIFT +: 16];
  assign q0_x255 = ({8'b0, q0} << 8) - {8'b0, q0};
  assign rr      = {1'b0, tsc} - q0_x255;
  assign q_fix   = (rr >= mwtg_pkg::DIVISOR_255) ? q0 + 16'd1 : q0;

  assign bin_sum  = 17'(sine_first) + 17'(rom_q);
  assign bin_half = 17'($signed(bin_sum + {16'b0, bin_sum[16]}) >>> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= '0;
      beat_step    <= '0;
      wave_select  <= mwtg_pkg::WAVE_SINE;
      volume_level <= mwtg_pkg::VOLUME_RESET;
      enable_bits  <= '0;
      rise_hold_ms <= '0;
      fall_rest_ms <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        mwtg_pkg::REG_PHASE_STEP:  phase_step   <= cfg_data[PHASE_BITS-1:0];
        mwtg_pkg::REG_BEAT_STEP:   beat_step    <= cfg_data[PHASE_BITS-1:0];
        mwtg_pkg::REG_WAVE_SELECT: wave_select  <= cfg_data[2:0];
        mwtg_pkg::REG_VOLUME:      volume_level <= cfg_data[7:0];
        mwtg_pkg::REG_ENABLE:      enable_bits  <= cfg_data[1:0];
        mwtg_pkg::REG_RISE_HOLD:   rise_hold_ms <= cfg_data;
        mwtg_pkg::REG_FALL_REST:   fall_rest_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod  <= mul_a * mul_b;
    rom_q <= sine_rom[rom_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      main_phase   <= '0;
      beat_phase   <= '0;
      sample_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        sample_valid <= 1'b1;
      end else if (!sample_stall) begin
        sample_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            elapsed <= elapsed_ms;
            if (enable_bits[0]) begin
              state <= S_RAW0;
            end else begin
              result <= '0;
              state  <= S_DONE;
            end
          end
        end
        S_RAW0: state <= S_RAW1;
        S_RAW1: state <= S_RAW2;
        S_RAW2: begin
          state <= S_ENV0;
          unique case (wave_select)
            mwtg_pkg::WAVE_SINE: raw <= rom_q;
            mwtg_pkg::WAVE_TRIANGLE, mwtg_pkg::WAVE_SAWTOOTH: begin
              raw <= vneg ? -$signed({1'b0, prod[46:32]}) : $signed({1'b0, prod[46:32]});
            end
            mwtg_pkg::WAVE_SQUARE: raw <= p32[31] ? -mwtg_pkg::FULL_AMP : mwtg_pkg::FULL_AMP;
            mwtg_pkg::WAVE_BINAURAL: begin
              sine_first <= rom_q;
              state      <= S_RAW3;
            end
            default: raw <= '0;
          endcase
        end
        S_RAW3: begin
          raw   <= 16'(bin_half);
          state <= S_ENV0;
        end
        S_ENV0: begin
          if (!enable_bits[1] || total == '0) begin
            env   <= mwtg_pkg::ENV_FULL;
            state <= S_SC0;
          end else begin
            dq      <= elapsed;
            rem     <= '0;
            divisor <= total;
            cnt     <= '1;
            state   <= S_DIVM;
          end
        end
        S_DIVM: begin
          dq  <= dq_new;
          rem <= rem_new;
          cnt <= cnt - 5'd1;
          if (cnt == '0) begin
            state <= S_SEG;
          end
        end
        S_SEG: begin
          priority if (rem < c0) begin
            dq      <= {rem[15:0], 16'b0};
            rem     <= '0;
            divisor <= c0;
            cnt     <= '1;
            state   <= S_DIVE;
          end else if (rem < c01) begin
            env   <= mwtg_pkg::ENV_FULL;
            state <= S_SC0;
          end else if (rem < c012) begin
            dq      <= {fall_left[15:0], 16'b0};
            rem     <= '0;
            divisor <= {2'b00, fall_rest_ms[15:0]};
            cnt     <= '1;
            state   <= S_DIVE;
          end else begin
            env   <= '0;
            state <= S_SC0;
          end
        end
        S_DIVE: begin
          dq  <= dq_new;
          rem <= rem_new;
          cnt <= cnt - 5'd1;
          if (cnt == '0) begin
            env   <= dq_new[16:0];
            state <= S_SC0;
          end
        end
        S_SC0: state <= S_SC1;
        S_SC1: state <= S_SC2;
        S_SC2: begin
          tsc   <= prod[38:16];
          state <= S_SC3;
        end
        S_SC3: begin
          result <= raw[15] ? -$signed(q_fix) : $signed(q_fix);
          state  <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            audio_sample <= result;
            if (enable_bits[0]) begin
              main_phase <= main_phase + phase_step;
              if (wave_select == mwtg_pkg::WAVE_BINAURAL) begin
                beat_phase <= beat_phase + beat_step;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Once a request is taken the sequencer must be busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> req_stall)
    else $error("request taken but sequencer not busy");

  // Scaled samples stay within the symmetric range.
  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    sample_valid |-> audio_sample != 16'sh8000)
    else $error("sample outside symmetric range");

  // The divider remainder stays below its divisor while iterating.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVM || state == S_DIVE) |-> (rem < divisor && divisor != '0))
    else $error("divider remainder out of range");

  // The main phase moves only when a sample beat is written out.
  a_phase_move: assert property (@(posedge clk) disable iff (rst)
    (!$stable(main_phase) && !$past(rst)) |-> ($past(state) == S_DONE && sample_valid))
    else $error("main phase advanced outside sample delivery");

endmodule
